@@ hdl/segment_clip_by_interfaces_core_defines.svh @@
// assertion macros used by the segment clip rtl
// needs clk and rst_n in the scope where a macro is used
`ifndef SEGMENT_CLIP_BY_INTERFACES_CORE_DEFINES_SVH
`define SEGMENT_CLIP_BY_INTERFACES_CORE_DEFINES_SVH

// property checked every clock edge outside reset
`define SCP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be true outside reset
`define SCP_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ hdl/scp_pkg.sv @@
// shared types and codes for the segment clip block
// no dependencies
package scp_pkg;

    // command codes
    localparam logic [1:0] CmdNone = 2'd0;
    localparam logic [1:0] CmdOne  = 2'd1;
    localparam logic [1:0] CmdTwo  = 2'd2;

    // axis codes
    localparam logic [1:0] AxisX = 2'd0;
    localparam logic [1:0] AxisY = 2'd1;
    localparam logic [1:0] AxisZ = 2'd2;

    // classified item handed from the front to the back
    typedef struct packed {
        logic        k0;
        logic        k1;
        logic        ca;
        logic        cb;
        logic [1:0]  ax;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [31:0] p1ax;
        logic [31:0] cell_id;
        logic [62:0] num_a;
        logic [62:0] num_b;
        logic [32:0] den_a;
        logic [32:0] den_b;
    } scp_job_t;

endpackage

@@ hdl/scp_front.sv @@
// front: accepts items, classifies endpoints and crossings, forms the
// interpolation numerators and denominators; depends on scp_pkg
module scp_front #(
    parameter int COORD_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              axis_wr_en,
    input  logic [1:0]        axis_wr_data,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        command,
    input  logic signed [31:0] origin_x,
    input  logic signed [31:0] origin_y,
    input  logic signed [31:0] origin_z,
    input  logic [30:0]       cell_length,
    input  logic              keep_side,
    input  logic signed [31:0] scalar_a0,
    input  logic signed [31:0] scalar_a1,
    input  logic signed [31:0] scalar_b0,
    input  logic signed [31:0] scalar_b1,
    input  logic [31:0]       cell_index,
    output logic              job_valid,
    input  logic              job_ready,
    output scp_pkg::scp_job_t job
);
    import scp_pkg::*;

    // saturation bounds of the far endpoint
    localparam logic signed [33:0] CoordHi = (COORD_WIDTH < 34) ?
        ((34'sd1 <<< (COORD_WIDTH - 1)) - 34'sd1) : {1'b0, {33{1'b1}}};
    localparam logic signed [33:0] CoordLo = -CoordHi - 34'sd1;

    typedef struct packed {
        logic        k0;
        logic        k1;
        logic        ca;
        logic        cb;
        logic [1:0]  ax;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [31:0] cell_id;
    } hdr_t;

    logic [1:0] axis_reg;

    logic              v1_reg, v2_reg, v3_reg;
    logic              r1, r2, r3;
    hdr_t              h1_reg, h2_reg;
    logic signed [31:0] x0_reg;
    logic signed [33:0] p1_reg;
    logic [31:0]       ma0_reg, ma1_reg, mb0_reg, mb1_reg;
    logic [31:0]       m2a_reg, m2b_reg;
    logic [31:0]       p1ax_reg;
    logic [30:0]       d_reg;
    logic [32:0]       dena_reg, denb_reg;
    scp_job_t          job_reg;

    hdr_t              h1_next;
    logic signed [31:0] x0_next;
    logic signed [33:0] sum;
    logic signed [33:0] p1_next;
    logic signed [33:0] diff;
    logic [30:0]       d_next;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg <= AxisX;
        end
        else if (axis_wr_en)
        begin
            axis_reg <= axis_wr_data;
        end
    end

    function automatic logic crosses(input logic signed [31:0] v0,
                                     input logic signed [31:0] v1);
        crosses = (v0 < 0 && v1 > 0) || (v0 > 0 && v1 < 0);
    endfunction

    function automatic logic [31:0] mag(input logic signed [31:0] v);
        mag = (v < 0) ? 32'(-v) : 32'(v);
    endfunction

    // stage handshake
    assign r3   = !v3_reg || job_ready;
    assign r2   = !v2_reg || r3;
    assign r1   = !v1_reg || r2;
    assign full = !r1;

    // stage 1 classification and far endpoint
    always_comb
    begin
        h1_next.ax      = (axis_reg > AxisZ) ? AxisZ : axis_reg;
        h1_next.px      = origin_x;
        h1_next.py      = origin_y;
        h1_next.pz      = origin_z;
        h1_next.cell_id = cell_index;
        unique case (h1_next.ax)
            AxisX:   x0_next = origin_x;
            AxisY:   x0_next = origin_y;
            default: x0_next = origin_z;
        endcase
        priority if (command == CmdNone)
        begin
            h1_next.k0 = 1'b1;
            h1_next.k1 = 1'b1;
            h1_next.ca = 1'b0;
            h1_next.cb = 1'b0;
        end
        else if (command == CmdOne)
        begin
            h1_next.k0 = keep_side ? (scalar_a0 <= 0) : (scalar_a0 >= 0);
            h1_next.k1 = keep_side ? (scalar_a1 <= 0) : (scalar_a1 >= 0);
            h1_next.ca = crosses(scalar_a0, scalar_a1);
            h1_next.cb = 1'b0;
        end
        else
        begin
            h1_next.k0 = (scalar_a0 >= 0) && (scalar_b0 <= 0);
            h1_next.k1 = (scalar_a1 >= 0) && (scalar_b1 <= 0);
            h1_next.ca = crosses(scalar_a0, scalar_a1);
            h1_next.cb = crosses(scalar_b0, scalar_b1);
        end
        sum = 34'(x0_next) + $signed({3'b000, cell_length});
        priority if (sum > CoordHi)
            p1_next = CoordHi;
        else if (sum < CoordLo)
            p1_next = CoordLo;
        else
            p1_next = sum;
    end

    // stage 2 axis span
    always_comb
    begin
        diff   = p1_reg - 34'(x0_reg);
        d_next = (p1_reg > 34'(x0_reg)) ? diff[30:0] : 31'd0;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (r1)
                v1_reg <= push;
            if (r2)
                v2_reg <= v1_reg;
            if (r3)
                v3_reg <= v2_reg;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (r1 && push)
        begin
            h1_reg  <= h1_next;
            x0_reg  <= x0_next;
            p1_reg  <= p1_next;
            ma0_reg <= mag(scalar_a0);
            ma1_reg <= mag(scalar_a1);
            mb0_reg <= mag(scalar_b0);
            mb1_reg <= mag(scalar_b1);
        end
        if (r2 && v1_reg)
        begin
            h2_reg   <= h1_reg;
            p1ax_reg <= p1_reg[31:0];
            d_reg    <= d_next;
            m2a_reg  <= ma0_reg;
            m2b_reg  <= mb0_reg;
            dena_reg <= {1'b0, ma0_reg} + {1'b0, ma1_reg};
            denb_reg <= {1'b0, mb0_reg} + {1'b0, mb1_reg};
        end
        if (r3 && v2_reg)
        begin
            job_reg.k0      <= h2_reg.k0;
            job_reg.k1      <= h2_reg.k1;
            job_reg.ca      <= h2_reg.ca;
            job_reg.cb      <= h2_reg.cb;
            job_reg.ax      <= h2_reg.ax;
            job_reg.px      <= h2_reg.px;
            job_reg.py      <= h2_reg.py;
            job_reg.pz      <= h2_reg.pz;
            job_reg.cell_id <= h2_reg.cell_id;
            job_reg.p1ax    <= p1ax_reg;
            job_reg.num_a   <= {31'd0, m2a_reg} * {32'd0, d_reg};
            job_reg.num_b   <= {31'd0, m2b_reg} * {32'd0, d_reg};
            job_reg.den_a   <= dena_reg;
            job_reg.den_b   <= denb_reg;
        end
    end

    assign job_valid = v3_reg;
    assign job       = job_reg;

endmodule

@@ hdl/scp_fifo.sv @@
// two-entry queue of classified items between front and back
// depends on scp_pkg
module scp_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  scp_pkg::scp_job_t wr_data,
    output logic              rd_valid,
    input  logic              rd_take,
    output scp_pkg::scp_job_t rd_data
);
    import scp_pkg::*;

    scp_job_t   mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign wr       = wr_valid && wr_ready;
    assign rd       = rd_take && rd_valid;
    assign rd_data  = mem_reg[rp_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr)
                wp_reg <= !wp_reg;
            if (rd)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_data;
    end

endmodule

@@ hdl/scp_back.sv @@
// back: divides out both crossings eight bits a cycle, then emits the
// ordered points of one item; depends on scp_pkg and the defines header
`include "segment_clip_by_interfaces_core_defines.svh"
module scp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    output logic              job_take,
    input  scp_pkg::scp_job_t job,
    output logic              empty,
    input  logic              pop,
    output logic              point_valid,
    output logic signed [31:0] point_x,
    output logic signed [31:0] point_y,
    output logic signed [31:0] point_z,
    output logic [31:0]       cell_index_out,
    output logic              last_point
);
    import scp_pkg::*;

    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] sh;
        logic [31:0] q;
    } div_t;

    // divider
    scp_job_t   dj_reg;
    div_t       da_reg, db_reg;
    logic       dv_busy_reg, dv_done_reg;
    logic [1:0] dv_cnt_reg;

    // emitter
    logic        em_valid_reg;
    logic [3:0]  mask_reg;
    logic [1:0]  eax_reg;
    logic [31:0] ex_reg, ey_reg, ez_reg, ec1_reg, ec2_reg, ep1_reg, ecell_reg;

    logic        em_last, load_em, start;
    logic [3:0]  mask_next, low_bit;
    logic [31:0] qlo, qhi, ax_coord, ax_base;
    div_t        da_in, db_in;

    function automatic div_t div8(input div_t s, input logic [32:0] den);
        div_t r;
        r = s;
        for (int i = 0; i < 8; i++)
        begin
            r.rem = {r.rem[32:0], r.sh[31]};
            r.sh  = {r.sh[30:0], 1'b0};
            if (r.rem >= {1'b0, den})
            begin
                r.rem = r.rem - {1'b0, den};
                r.q   = {r.q[30:0], 1'b1};
            end
            else
            begin
                r.q = {r.q[30:0], 1'b0};
            end
        end
        div8 = r;
    endfunction

    // handoff control
    assign em_last  = ((mask_reg & (mask_reg - 4'd1)) == 4'd0);
    assign load_em  = dv_done_reg && (!em_valid_reg || (pop && em_last));
    assign start    = job_valid && !dv_busy_reg && (!dv_done_reg || load_em);
    assign job_take = start;

    always_comb
    begin
        da_in.rem = {3'b000, job.num_a[62:32]};
        da_in.sh  = job.num_a[31:0];
        da_in.q   = 32'd0;
        db_in.rem = {3'b000, job.num_b[62:32]};
        db_in.sh  = job.num_b[31:0];
        db_in.q   = 32'd0;
    end

    // divider control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_busy_reg <= 1'b0;
            dv_done_reg <= 1'b0;
            dv_cnt_reg  <= 2'd0;
        end
        else if (start)
        begin
            dv_busy_reg <= 1'b1;
            dv_done_reg <= 1'b0;
            dv_cnt_reg  <= 2'd1;
        end
        else if (dv_busy_reg)
        begin
            dv_cnt_reg <= dv_cnt_reg + 2'd1;
            if (dv_cnt_reg == 2'd3)
            begin
                dv_busy_reg <= 1'b0;
                dv_done_reg <= 1'b1;
            end
        end
        else if (load_em)
        begin
            dv_done_reg <= 1'b0;
        end
    end

    // divider datapath, first eight bits on the load cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dj_reg <= job;
            da_reg <= div8(da_in, job.den_a);
            db_reg <= div8(db_in, job.den_b);
        end
        else if (dv_busy_reg)
        begin
            da_reg <= div8(da_reg, dj_reg.den_a);
            db_reg <= div8(db_reg, dj_reg.den_b);
        end
    end

    // point list of the finished item
    always_comb
    begin
        unique case (dj_reg.ax)
            AxisX:   ax_base = dj_reg.px;
            AxisY:   ax_base = dj_reg.py;
            default: ax_base = dj_reg.pz;
        endcase
        priority if (dj_reg.ca && dj_reg.cb)
        begin
            qlo = (da_reg.q < db_reg.q) ? da_reg.q : db_reg.q;
            qhi = (da_reg.q < db_reg.q) ? db_reg.q : da_reg.q;
        end
        else if (dj_reg.ca)
        begin
            qlo = da_reg.q;
            qhi = da_reg.q;
        end
        else
        begin
            qlo = db_reg.q;
            qhi = db_reg.q;
        end
        mask_next = {dj_reg.k1,
                     dj_reg.ca && dj_reg.cb && (qlo != qhi),
                     dj_reg.ca || dj_reg.cb,
                     dj_reg.k0};
    end

    // emitter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            em_valid_reg <= 1'b0;
            mask_reg     <= 4'd0;
        end
        else if (load_em)
        begin
            em_valid_reg <= 1'b1;
            mask_reg     <= mask_next;
        end
        else if (pop && em_valid_reg)
        begin
            if (em_last)
                em_valid_reg <= 1'b0;
            else
                mask_reg <= mask_reg & (mask_reg - 4'd1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_em)
        begin
            eax_reg   <= dj_reg.ax;
            ex_reg    <= dj_reg.px;
            ey_reg    <= dj_reg.py;
            ez_reg    <= dj_reg.pz;
            ec1_reg   <= ax_base + qlo;
            ec2_reg   <= ax_base + qhi;
            ep1_reg   <= dj_reg.p1ax;
            ecell_reg <= dj_reg.cell_id;
        end
    end

    // current point: lowest pending slot
    always_comb
    begin
        low_bit = mask_reg & (~mask_reg + 4'd1);
        unique case (eax_reg)
            AxisX:   ax_coord = ex_reg;
            AxisY:   ax_coord = ey_reg;
            default: ax_coord = ez_reg;
        endcase
        if (low_bit[1])
            ax_coord = ec1_reg;
        else if (low_bit[2])
            ax_coord = ec2_reg;
        else if (low_bit[3])
            ax_coord = ep1_reg;
        point_valid = (mask_reg != 4'd0);
        point_x = !point_valid ? 32'sd0 : (eax_reg == AxisX) ? ax_coord : ex_reg;
        point_y = !point_valid ? 32'sd0 : (eax_reg == AxisY) ? ax_coord : ey_reg;
        point_z = !point_valid ? 32'sd0 :
                  (eax_reg != AxisX && eax_reg != AxisY) ? ax_coord : ez_reg;
    end

    assign empty          = !em_valid_reg;
    assign cell_index_out = ecell_reg;
    assign last_point     = em_last;

    `SCP_NEVER(a_busy_done, dv_busy_reg && dv_done_reg, "divider busy and done at once")
    `SCP_ASSERT(a_empty_last, (!empty && !point_valid) |-> last_point, "empty clip not last")
    `SCP_ASSERT(a_div_len, (dv_busy_reg && dv_cnt_reg == 2'd3) |=> dv_done_reg, "divider overran")

endmodule

@@ hdl/segment_clip_by_interfaces_core.sv @@
// Segment clip against up to two interface fields. An item enters a
// three-stage front (far endpoint, span, multiply), waits in a two-entry
// queue, and is divided in the back, eight quotient bits a cycle for both
// crossings at once; the emitter then gives one to four points, or one
// empty marker, one per cycle while pop is held. The divider can take the
// next item while the emitter still gives out the points of the last one.
// top level: ties front, queue and back; depends on scp_pkg
module segment_clip_by_interfaces_core #(
    parameter int COORD_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              axis_wr_en,
    input  logic [1:0]        axis_wr_data,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        command,
    input  logic signed [31:0] origin_x,
    input  logic signed [31:0] origin_y,
    input  logic signed [31:0] origin_z,
    input  logic [30:0]       cell_length,
    input  logic              keep_side,
    input  logic signed [31:0] scalar_a0,
    input  logic signed [31:0] scalar_a1,
    input  logic signed [31:0] scalar_b0,
    input  logic signed [31:0] scalar_b1,
    input  logic [31:0]       cell_index,
    output logic              empty,
    input  logic              pop,
    output logic              point_valid,
    output logic signed [31:0] point_x,
    output logic signed [31:0] point_y,
    output logic signed [31:0] point_z,
    output logic [31:0]       cell_index_out,
    output logic              last_point
);
    import scp_pkg::*;

    logic     f_valid, f_ready, q_valid, q_take;
    scp_job_t f_job, q_job;

    // front
    scp_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .axis_wr_en   (axis_wr_en),
        .axis_wr_data (axis_wr_data),
        .push         (push),
        .full         (full),
        .command      (command),
        .origin_x     (origin_x),
        .origin_y     (origin_y),
        .origin_z     (origin_z),
        .cell_length  (cell_length),
        .keep_side    (keep_side),
        .scalar_a0    (scalar_a0),
        .scalar_a1    (scalar_a1),
        .scalar_b0    (scalar_b0),
        .scalar_b1    (scalar_b1),
        .cell_index   (cell_index),
        .job_valid    (f_valid),
        .job_ready    (f_ready),
        .job          (f_job)
    );

    // queue
    scp_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_job),
        .rd_valid (q_valid),
        .rd_take  (q_take),
        .rd_data  (q_job)
    );

    // back
    scp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .job_valid      (q_valid),
        .job_take       (q_take),
        .job            (q_job),
        .empty          (empty),
        .pop            (pop),
        .point_valid    (point_valid),
        .point_x        (point_x),
        .point_y        (point_y),
        .point_z        (point_z),
        .cell_index_out (cell_index_out),
        .last_point     (last_point)
    );

endmodule

@@ dv/segment_clip_by_interfaces_core_checker.sv @@
// checker for the segment clip block: predicts points from each accepted item
// and compares them with the accepted results; depends on scp_pkg
module segment_clip_by_interfaces_core_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              axis_wr_en,
    input  logic [1:0]        axis_wr_data,
    input  logic              push,
    input  logic              full,
    input  logic [1:0]        command,
    input  logic signed [31:0] origin_x,
    input  logic signed [31:0] origin_y,
    input  logic signed [31:0] origin_z,
    input  logic [30:0]       cell_length,
    input  logic              keep_side,
    input  logic signed [31:0] scalar_a0,
    input  logic signed [31:0] scalar_a1,
    input  logic signed [31:0] scalar_b0,
    input  logic signed [31:0] scalar_b1,
    input  logic [31:0]       cell_index,
    input  logic              empty,
    input  logic              pop,
    input  logic              point_valid,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    input  logic [31:0]       cell_index_out,
    input  logic              last_point,
    output int                errors,
    output int                pending,
    output int                points_seen,
    output int                empties_seen
);
    import scp_pkg::*;

    typedef struct packed {
        logic        valid;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] cell_id;
        logic        last;
    } point_t;

    point_t      point_queue[$];
    logic [1:0]  axis_reg;

    assign pending = point_queue.size();

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic longint cross_coord(longint x0, longint span, longint v0, longint v1);
        longint m0;
        longint m1;
        m0 = v0 < 0 ? -v0 : v0;
        m1 = v1 < 0 ? -v1 : v1;
        return x0 + (m0 * span) / (m0 + m1);
    endfunction

    function automatic logic sign_change(longint v0, longint v1);
        return (v0 < 0 && v1 > 0) || (v0 > 0 && v1 < 0);
    endfunction

    // work out the points of one item
    task automatic predict_points();
        int     ax;
        longint p0[3];
        longint p1[3];
        longint q[3];
        longint a0, a1, b0, b1, span, xa, xb, lo, hi;
        logic   ca, cb;
        int     n;
        point_t pt;
        ax = (axis_reg > AxisZ) ? 2 : int'(axis_reg);
        p0[0] = origin_x; p0[1] = origin_y; p0[2] = origin_z;
        a0 = scalar_a0; a1 = scalar_a1; b0 = scalar_b0; b1 = scalar_b1;
        p1 = p0;
        p1[ax] = p0[ax] + longint'(cell_length);
        if (p1[ax] > 64'sd2147483647) p1[ax] = 64'sd2147483647;
        span = p1[ax] > p0[ax] ? p1[ax] - p0[ax] : 0;
        n = 0;
        pt = '0;
        pt.valid = 1'b1;
        pt.cell_id = cell_index;
        if (command == CmdNone) begin
            pt.x = 32'(p0[0]); pt.y = 32'(p0[1]); pt.z = 32'(p0[2]);
            point_queue.push_back(pt);
            pt.x = 32'(p1[0]); pt.y = 32'(p1[1]); pt.z = 32'(p1[2]);
            point_queue.push_back(pt);
            n = 2;
        end
        else if (command == CmdOne) begin
            if (keep_side ? a0 <= 0 : a0 >= 0) begin
                pt.x = 32'(p0[0]); pt.y = 32'(p0[1]); pt.z = 32'(p0[2]);
                point_queue.push_back(pt); n++;
            end
            if (sign_change(a0, a1)) begin
                q = p0;
                q[ax] = cross_coord(p0[ax], span, a0, a1);
                pt.x = 32'(q[0]); pt.y = 32'(q[1]); pt.z = 32'(q[2]);
                point_queue.push_back(pt); n++;
            end
            if (keep_side ? a1 <= 0 : a1 >= 0) begin
                pt.x = 32'(p1[0]); pt.y = 32'(p1[1]); pt.z = 32'(p1[2]);
                point_queue.push_back(pt); n++;
            end
        end
        else begin
            ca = sign_change(a0, a1);
            cb = sign_change(b0, b1);
            xa = ca ? cross_coord(p0[ax], span, a0, a1) : 0;
            xb = cb ? cross_coord(p0[ax], span, b0, b1) : 0;
            if (a0 >= 0 && b0 <= 0) begin
                pt.x = 32'(p0[0]); pt.y = 32'(p0[1]); pt.z = 32'(p0[2]);
                point_queue.push_back(pt); n++;
            end
            if (ca || cb) begin
                lo = (ca && cb) ? (xa < xb ? xa : xb) : (ca ? xa : xb);
                hi = (ca && cb) ? (xa < xb ? xb : xa) : lo;
                q = p0;
                q[ax] = lo;
                pt.x = 32'(q[0]); pt.y = 32'(q[1]); pt.z = 32'(q[2]);
                point_queue.push_back(pt); n++;
                if (hi != lo) begin
                    q[ax] = hi;
                    pt.x = 32'(q[0]); pt.y = 32'(q[1]); pt.z = 32'(q[2]);
                    point_queue.push_back(pt); n++;
                end
            end
            if (a1 >= 0 && b1 <= 0) begin
                pt.x = 32'(p1[0]); pt.y = 32'(p1[1]); pt.z = 32'(p1[2]);
                point_queue.push_back(pt); n++;
            end
        end
        // empty clip gives a single marker
        if (n == 0) begin
            pt = '0;
            pt.cell_id = cell_index;
            point_queue.push_back(pt);
        end
        pt = point_queue.pop_back();
        pt.last = 1'b1;
        point_queue.push_back(pt);
    endtask

    // compare one result with the oldest expectation
    task automatic check_point();
        point_t want;
        if (point_queue.size() == 0) begin
            report("unexpected result", cell_index_out, '0);
            return;
        end
        want = point_queue.pop_front();
        if (point_valid) points_seen++; else empties_seen++;
        if (point_valid !== want.valid)
            report("point_valid", 32'(point_valid), 32'(want.valid));
        if (point_x !== want.x) report("point_x", point_x, want.x);
        if (point_y !== want.y) report("point_y", point_y, want.y);
        if (point_z !== want.z) report("point_z", point_z, want.z);
        if (cell_index_out !== want.cell_id)
            report("cell_index_out", cell_index_out, want.cell_id);
        if (last_point !== want.last)
            report("last_point", 32'(last_point), 32'(want.last));
    endtask

    // watch both channels and the register port
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            axis_reg <= AxisX;
            errors = 0;
            points_seen = 0;
            empties_seen = 0;
            point_queue.delete();
        end
        else begin
            if (push && !full) predict_points();
            if (pop && !empty) check_point();
            if (axis_wr_en) axis_reg <= axis_wr_data;
        end
    end
endmodule

@@ dv/segment_clip_by_interfaces_core_test.sv @@
// testbench top for the segment clip block: clock, reset, stimulus, verdict
// depends on scp_pkg, the block and segment_clip_by_interfaces_core_checker
module segment_clip_by_interfaces_core_test;
    import scp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              axis_wr_en = 1'b0;
    logic [1:0]        axis_wr_data = '0;
    logic              push = 1'b0;
    logic              full;
    logic [1:0]        command = '0;
    logic signed [31:0] origin_x = '0;
    logic signed [31:0] origin_y = '0;
    logic signed [31:0] origin_z = '0;
    logic [30:0]       cell_length = '0;
    logic              keep_side = 1'b0;
    logic signed [31:0] scalar_a0 = '0;
    logic signed [31:0] scalar_a1 = '0;
    logic signed [31:0] scalar_b0 = '0;
    logic signed [31:0] scalar_b1 = '0;
    logic [31:0]       cell_index = '0;
    logic              empty;
    logic              pop = 1'b0;
    logic              point_valid;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [31:0]       cell_index_out;
    logic              last_point;

    int errors;
    int pending;
    int points_seen;
    int empties_seen;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    int items_sent = 0;
    logic hold_req = 1'b0;
    logic hold_seen = 1'b0;

    always #6 clk = ~clk;

    segment_clip_by_interfaces_core i_dut (.*);

    segment_clip_by_interfaces_core_checker i_checker (.*);

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL segment_clip_by_interfaces_core");
            $finish;
        end
    end

    // receiver: random stalls plus one long hold-off on request
    always @(posedge clk) begin
        if (hold_req && !hold_seen) begin
            hold_seen <= 1'b1;
            hold_cycles <= 200;
            pop <= 1'b0;
        end
        else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            pop <= 1'b0;
        end
        else begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [31:0] pick_scalar();
        unique case ($urandom_range(5))
            0: return 32'sd0;
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            3: return $urandom_range(200000) - 100000;
            default: return $urandom;
        endcase
    endfunction

    // offer one item and wait until it is taken
    task automatic send_cell(input logic [1:0] cmd, input logic [31:0] ox, input logic [31:0] oy,
                             input logic [31:0] oz, input logic [30:0] len, input logic ks,
                             input logic [31:0] a0, input logic [31:0] a1,
                             input logic [31:0] b0, input logic [31:0] b1);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        command <= cmd;
        origin_x <= ox;
        origin_y <= oy;
        origin_z <= oz;
        cell_length <= len;
        keep_side <= ks;
        scalar_a0 <= a0;
        scalar_a1 <= a1;
        scalar_b0 <= b0;
        scalar_b1 <= b1;
        cell_index <= $urandom;
        push <= 1'b1;
        @(posedge clk);
        while (full) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_random();
        logic [30:0] len;
        len = $urandom_range(3) == 0 ? 31'($urandom) : 31'($urandom_range(1 << 20));
        send_cell(2'($urandom_range(3)), pick_scalar(), pick_scalar(), pick_scalar(), len,
                  1'($urandom_range(1)), pick_scalar(), pick_scalar(), pick_scalar(),
                  pick_scalar());
    endtask

    // wait for the block to drain, then write the axis register
    task automatic set_axis(input logic [1:0] value);
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (12) @(posedge clk);
        axis_wr_en <= 1'b1;
        axis_wr_data <= value;
        @(posedge clk);
        axis_wr_en <= 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every command, extremes, equal crossings, overflow
        send_cell(CmdNone, '0, '0, '0, '0, 1'b0, '0, '0, '0, '0);
        send_cell(CmdNone, 32'h7fff_0000, 32'd1, 32'd2, 31'h7fff_ffff, 1'b0,
                  '0, '0, '0, '0);
        send_cell(CmdOne, '0, '0, '0, 31'h10000, 1'b0, -32'sd5, 32'sd5, '0, '0);
        send_cell(CmdOne, '0, '0, '0, 31'h10000, 1'b1, -32'sd5, 32'sd5, '0, '0);
        send_cell(CmdOne, 32'd5, 32'd6, 32'd7, 31'd100, 1'b0, '0, '0, '0, '0);
        send_cell(CmdOne, 32'd5, 32'd6, 32'd7, 31'd100, 1'b0, -32'sd1, -32'sd1, '0, '0);
        send_cell(CmdOne, 32'h8000_0000, '0, '0, 31'h7fff_ffff, 1'b1,
                  32'h8000_0000, 32'h7fff_ffff, '0, '0);
        send_cell(CmdTwo, '0, '0, '0, 31'd1000, 1'b0, -32'sd3, 32'sd3, 32'sd3, -32'sd3);
        send_cell(CmdTwo, '0, '0, '0, 31'd1000, 1'b0, 32'sd1, -32'sd3, -32'sd2, 32'sd2);
        send_cell(CmdTwo, '0, '0, '0, 31'd1000, 1'b0, -32'sd1, -32'sd1, 32'sd1, 32'sd1);
        send_cell(2'd3, '0, '0, '0, 31'd1000, 1'b0, 32'sd1, 32'sd1, -32'sd1, -32'sd1);
        send_cell(2'd3, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 31'h7fff_ffff, 1'b1,
                  32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        set_axis(AxisY);
        send_cell(CmdOne, '0, 32'h7fff_fff0, '0, 31'h7fff_ffff, 1'b0, 32'sd4, -32'sd4,
                  '0, '0);
        set_axis(2'd3);
        send_cell(CmdTwo, 32'd1, 32'd2, 32'h7000_0000, 31'h4000_0000, 1'b0, -32'sd7, 32'sd9,
                  32'sd2, -32'sd8);

        // random phases with different idling, axis changed between them
        for (int phase = 0; phase < 5; phase++) begin
            set_axis(phase == 4 ? AxisX : 2'($urandom_range(3)));
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                3: begin send_idle_pct = 11; recv_stall_pct = 11; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; hold_req <= 1'b1; end
            endcase
            repeat (phase == 4 ? 14 : 64) send_random();
        end

        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("covered %0d items, %0d points and %0d empty clips over all axes",
                 items_sent, points_seen, empties_seen);
        $display("idling phases: none, sender, receiver, both, and a long receiver hold-off");
        if (errors == 0 && pending == 0) begin
            $display("PASS segment_clip_by_interfaces_core");
        end
        else begin
            $display("FAIL segment_clip_by_interfaces_core");
        end
        $finish;
    end
endmodule
